// ===== rtl/bpm_pkg.sv =====
`timescale 1ns / 1ps

package bpm_pkg;

  // one frame in
  typedef struct packed {
    logic [15:0] eye_ratio;
    logic [31:0] time_ms;
  } in_t;

  // one result out
  typedef struct packed {
    logic        blink_seen;
    logic        eyes_shut;
    logic [16:0] closed_fraction;
    logic [15:0] blinks_per_minute;
  } out_t;

  // configuration port geometry
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 20;

  // register indexes
  localparam logic [CfgIdxW-1:0] RegClosedThreshold = 2'd0;
  localparam logic [CfgIdxW-1:0] RegDebounceMs      = 2'd1;
  localparam logic [CfgIdxW-1:0] RegClosedWindowMs  = 2'd2;
  localparam logic [CfgIdxW-1:0] RegBlinkWindowMs   = 2'd3;

  // register reset values
  localparam logic [15:0] ClosedThresholdRst = 16'd3277;
  localparam logic [15:0] DebounceMsRst      = 16'd200;
  localparam logic [15:0] ClosedWindowMsRst  = 16'd5000;
  localparam logic [19:0] BlinkWindowMsRst   = 20'd60000;

  // 60000 ms per minute times 64 for the Q10.6 rate
  localparam int unsigned RateScaleW = 22;
  localparam logic [RateScaleW-1:0] RateScale = 22'd3840000;

  // width of time stamps and spans
  localparam int unsigned TimeW = 32;

endpackage

// ===== rtl/bpm_ram.sv =====
`timescale 1ns / 1ps

module bpm_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/bpm_div.sv =====
`timescale 1ns / 1ps

module bpm_div #(
  parameter int unsigned NUM_W = 34,
  parameter int unsigned DEN_W = 32
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [NUM_W-1:0] num_i,
  input  logic [DEN_W-1:0] den_i,
  output logic             done_o,
  output logic [NUM_W-1:0] quot_o
);

  localparam int unsigned CntW = $clog2(NUM_W + 1);

  logic             busy_q;
  logic             done_q;
  logic [CntW-1:0]  cnt_q;
  logic [NUM_W-1:0] acc_q;
  logic [DEN_W-1:0] den_q;
  logic [DEN_W-1:0] rem_q;

  logic [DEN_W:0]   rem_sh;
  logic             fits;
  logic [DEN_W:0]   rem_d;

  // one restoring step: shift in the next numerator bit, try to subtract
  always_comb begin
    rem_sh = {rem_q, acc_q[NUM_W-1]};
    fits   = rem_sh >= {1'b0, den_q};
    rem_d  = fits ? (rem_sh - {1'b0, den_q}) : rem_sh;
  end

  // numerator shifts out at the top while quotient bits shift in at the bottom
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= busy_q && !start_i && (cnt_q == CntW'(1));
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CntW'(NUM_W);
      end else if (busy_q) begin
        cnt_q <= cnt_q - CntW'(1);
        if (cnt_q == CntW'(1)) begin
          busy_q <= 1'b0;
        end
      end
    end
  end

  // datapath needs no reset
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      acc_q <= num_i;
      den_q <= den_i;
      rem_q <= '0;
    end else if (busy_q) begin
      acc_q <= {acc_q[NUM_W-2:0], fits};
      rem_q <= rem_d[DEN_W-1:0];
    end
  end

  assign done_o = done_q;
  assign quot_o = acc_q;

endmodule

// ===== rtl/blink_perclos_monitor_unit.sv =====
`timescale 1ns / 1ps

// eye-closure (PERCLOS) and blink-rate monitor
//
// in channel: one transaction per video frame (eye_ratio Q2.14, time_ms).
// out channel: exactly one transaction per frame with the blink flag, the
// eyes-closed flag, PERCLOS in Q1.16 and the blink rate in Q10.6.
// config port: plain write (cfg_we_i, cfg_idx_i, cfg_data_i), no read-back;
// write only while no frame is in flight.
// in_ready_o rises together with out_valid_o, so a new frame is taken only once
// the last result is in the output register. Frame time is set by the
// bit-serial divider (DIV_NUM_W is 32 at the default depths), used once for
// PERCLOS and once for the rate, by one read-compare step per expired history
// entry or blink, and by an extra pop when the history is full. The rate
// division is skipped when there are no blinks or the span is zero.
// a finished result waits in the output register; a stalled receiver only
// holds the sequencer at its last step if a second result is already done.
// reset: rings empty, eyes open, no blink, rate zero, registers at defaults;
// ring memories are not cleared, only counted entries are read.

module blink_perclos_monitor_unit #(
  parameter int unsigned HISTORY_DEPTH = 256,
  parameter int unsigned BLINK_DEPTH   = 64
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  bpm_pkg::in_t                   in_data_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output bpm_pkg::out_t                  out_data_o,
  input  logic                           cfg_we_i,
  input  logic [bpm_pkg::CfgIdxW-1:0]    cfg_idx_i,
  input  logic [bpm_pkg::CfgDataW-1:0]   cfg_data_i
);

  localparam int unsigned TW     = bpm_pkg::TimeW;
  localparam int unsigned HAW    = $clog2(HISTORY_DEPTH);
  localparam int unsigned HCW    = $clog2(HISTORY_DEPTH + 1);
  localparam int unsigned BAW    = $clog2(BLINK_DEPTH);
  localparam int unsigned BCW    = $clog2(BLINK_DEPTH + 1);
  localparam int unsigned HSUM_W = HCW + 1;
  localparam int unsigned BSUM_W = BCW + 1;
  localparam int unsigned FRAC_NUM_W = HCW + 17;
  localparam int unsigned RATE_PROD_W = BCW + bpm_pkg::RateScaleW;
  localparam int unsigned RATE_NUM_W  = ((RATE_PROD_W > TW - 1) ? RATE_PROD_W : TW - 1) + 1;
  localparam int unsigned DIV_NUM_W   = (FRAC_NUM_W > RATE_NUM_W) ? FRAC_NUM_W : RATE_NUM_W;

  typedef enum logic [3:0] {
    S_IDLE,
    S_HFULL_RD,
    S_HFULL_POP,
    S_PUSH,
    S_HRD,
    S_HCHK,
    S_BRD,
    S_BCHK,
    S_FRAC,
    S_FRAC_WAIT,
    S_RATE,
    S_RATE_WAIT,
    S_OUT
  } state_e;

  // configuration registers
  logic [15:0] closed_thr_q;
  logic [15:0] debounce_q;
  logic [15:0] closed_win_q;
  logic [19:0] blink_win_q;

  // sequencer and frame state
  state_e         state_q;
  logic [TW-1:0]  now_q;
  logic           closed_q;
  logic           shut_flag_q;
  logic           have_blink_q;
  logic [TW-1:0]  last_blink_q;
  logic [HAW-1:0] hist_head_q;
  logic [HCW-1:0] hist_count_q;
  logic [HCW-1:0] shut_count_q;
  logic [BAW-1:0] blink_head_q;
  logic [BCW-1:0] blink_count_q;
  logic [15:0]    rate_hold_q;
  logic [16:0]    frac_q;
  logic [TW-1:0]  span_q;
  logic           blink_seen_q;
  logic           out_valid_q;
  bpm_pkg::out_t  out_q;

  // memory ports
  logic [TW:0]    hist_rdata;
  logic [TW-1:0]  blink_rdata;
  logic [HAW-1:0] hist_slot;
  logic [BAW-1:0] blink_slot;
  logic [HAW-1:0] hist_head_d;
  logic [BAW-1:0] blink_head_d;
  logic [HSUM_W-1:0] hist_sum;
  logic [BSUM_W-1:0] blink_sum;
  logic           hist_we;
  logic           blink_we;
  logic           blink_push;

  // age checks
  logic [TW-1:0]  hist_age;
  logic [TW-1:0]  blink_age;
  logic           hist_expired;
  logic           blink_expired;

  // divider
  logic                 div_start;
  logic [DIV_NUM_W-1:0] div_num;
  logic [TW-1:0]        div_den;
  logic                 div_done;
  logic [DIV_NUM_W-1:0] div_quot;

  // ring index arithmetic with wrap at any depth
  always_comb begin
    hist_sum  = HSUM_W'(hist_head_q) + HSUM_W'(hist_count_q);
    if (hist_sum >= HSUM_W'(HISTORY_DEPTH)) begin
      hist_sum = hist_sum - HSUM_W'(HISTORY_DEPTH);
    end
    hist_slot = hist_sum[HAW-1:0];
    blink_sum = BSUM_W'(blink_head_q) + BSUM_W'(blink_count_q);
    if (blink_sum >= BSUM_W'(BLINK_DEPTH)) begin
      blink_sum = blink_sum - BSUM_W'(BLINK_DEPTH);
    end
    blink_slot   = blink_sum[BAW-1:0];
    hist_head_d  = (hist_head_q == HAW'(HISTORY_DEPTH - 1)) ? '0 : hist_head_q + HAW'(1);
    blink_head_d = (blink_head_q == BAW'(BLINK_DEPTH - 1)) ? '0 : blink_head_q + BAW'(1);
  end

  // expiry and blink decisions
  always_comb begin
    hist_age      = now_q - hist_rdata[TW-1:0];
    blink_age     = now_q - blink_rdata;
    hist_expired  = hist_age > TW'(closed_win_q);
    blink_expired = blink_age > TW'(blink_win_q);
    blink_push    = !closed_q && shut_flag_q &&
                    (!have_blink_q || ((now_q - last_blink_q) > TW'(debounce_q)));
    hist_we       = (state_q == S_PUSH);
    blink_we      = (state_q == S_PUSH) && blink_push;
  end

  // divider operands: PERCLOS first, then blink rate
  always_comb begin
    div_start = 1'b0;
    div_num   = DIV_NUM_W'({shut_count_q, 16'h0000}) + DIV_NUM_W'(hist_count_q >> 1);
    div_den   = TW'(hist_count_q);
    case (state_q)
      S_FRAC: begin
        div_start = (hist_count_q != '0);
      end
      S_RATE: begin
        div_num   = DIV_NUM_W'(blink_count_q) * DIV_NUM_W'(bpm_pkg::RateScale)
                  + DIV_NUM_W'(span_q >> 1);
        div_den   = span_q;
        div_start = (blink_count_q != '0) && (span_q != '0);
      end
      default: begin
      end
    endcase
  end

  bpm_ram #(
    .WIDTH (TW + 1),
    .DEPTH (HISTORY_DEPTH)
  ) u_hist_ram (
    .clk_i   (clk_i),
    .we_i    (hist_we),
    .waddr_i (hist_slot),
    .wdata_i ({closed_q, now_q}),
    .raddr_i (hist_head_q),
    .rdata_o (hist_rdata)
  );

  bpm_ram #(
    .WIDTH (TW),
    .DEPTH (BLINK_DEPTH)
  ) u_blink_ram (
    .clk_i   (clk_i),
    .we_i    (blink_we),
    .waddr_i (blink_slot),
    .wdata_i (now_q),
    .raddr_i (blink_head_q),
    .rdata_o (blink_rdata)
  );

  bpm_div #(
    .NUM_W (DIV_NUM_W),
    .DEN_W (TW)
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (div_num),
    .den_i   (div_den),
    .done_o  (div_done),
    .quot_o  (div_quot)
  );

  // configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      closed_thr_q <= bpm_pkg::ClosedThresholdRst;
      debounce_q   <= bpm_pkg::DebounceMsRst;
      closed_win_q <= bpm_pkg::ClosedWindowMsRst;
      blink_win_q  <= bpm_pkg::BlinkWindowMsRst;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        bpm_pkg::RegClosedThreshold: closed_thr_q <= cfg_data_i[15:0];
        bpm_pkg::RegDebounceMs:      debounce_q   <= cfg_data_i[15:0];
        bpm_pkg::RegClosedWindowMs:  closed_win_q <= cfg_data_i[15:0];
        bpm_pkg::RegBlinkWindowMs:   blink_win_q  <= cfg_data_i[19:0];
        default: begin
        end
      endcase
    end
  end

  // frame sequencer with its registered outputs
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= S_IDLE;
      now_q         <= '0;
      closed_q      <= 1'b0;
      shut_flag_q   <= 1'b0;
      have_blink_q  <= 1'b0;
      last_blink_q  <= '0;
      hist_head_q   <= '0;
      hist_count_q  <= '0;
      shut_count_q  <= '0;
      blink_head_q  <= '0;
      blink_count_q <= '0;
      rate_hold_q   <= '0;
      frac_q        <= '0;
      span_q        <= '0;
      blink_seen_q  <= 1'b0;
      out_valid_q   <= 1'b0;
      out_q         <= '0;
    end else begin
      if (out_valid_q && out_ready_i && (state_q != S_OUT)) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (in_valid_i) begin
            now_q        <= in_data_i.time_ms;
            closed_q     <= in_data_i.eye_ratio < closed_thr_q;
            blink_seen_q <= 1'b0;
            state_q      <= (hist_count_q == HCW'(HISTORY_DEPTH)) ? S_HFULL_RD : S_PUSH;
          end
        end
        S_HFULL_RD: begin
          state_q <= S_HFULL_POP;
        end
        // full history: drop the oldest entry first
        S_HFULL_POP: begin
          if (hist_rdata[TW]) begin
            shut_count_q <= shut_count_q - HCW'(1);
          end
          hist_head_q  <= hist_head_d;
          hist_count_q <= hist_count_q - HCW'(1);
          state_q      <= S_PUSH;
        end
        // append to history, detect a blink and append to the blink ring
        S_PUSH: begin
          hist_count_q <= hist_count_q + HCW'(1);
          if (closed_q) begin
            shut_count_q <= shut_count_q + HCW'(1);
            shut_flag_q  <= 1'b1;
          end else begin
            shut_flag_q <= 1'b0;
          end
          if (blink_push) begin
            if (blink_count_q == BCW'(BLINK_DEPTH)) begin
              blink_head_q <= blink_head_d;
            end else begin
              blink_count_q <= blink_count_q + BCW'(1);
            end
            have_blink_q <= 1'b1;
            last_blink_q <= now_q;
            blink_seen_q <= 1'b1;
          end
          state_q <= S_HRD;
        end
        S_HRD: begin
          state_q <= S_HCHK;
        end
        // expire old history entries one at a time
        S_HCHK: begin
          if (hist_count_q != '0 && hist_expired) begin
            if (hist_rdata[TW]) begin
              shut_count_q <= shut_count_q - HCW'(1);
            end
            hist_head_q  <= hist_head_d;
            hist_count_q <= hist_count_q - HCW'(1);
            state_q      <= S_HRD;
          end else begin
            state_q <= S_BRD;
          end
        end
        S_BRD: begin
          state_q <= S_BCHK;
        end
        // expire old blinks, keep the span to the oldest survivor
        S_BCHK: begin
          if (blink_count_q != '0 && blink_expired) begin
            blink_head_q  <= blink_head_d;
            blink_count_q <= blink_count_q - BCW'(1);
            state_q       <= S_BRD;
          end else begin
            span_q  <= blink_age;
            state_q <= S_FRAC;
          end
        end
        S_FRAC: begin
          if (hist_count_q != '0) begin
            state_q <= S_FRAC_WAIT;
          end else begin
            frac_q  <= '0;
            state_q <= S_RATE;
          end
        end
        S_FRAC_WAIT: begin
          if (div_done) begin
            frac_q  <= div_quot[16:0];
            state_q <= S_RATE;
          end
        end
        // no blinks clears the rate, a zero span keeps it
        S_RATE: begin
          if (blink_count_q == '0) begin
            rate_hold_q <= '0;
            state_q     <= S_OUT;
          end else if (span_q == '0) begin
            state_q <= S_OUT;
          end else begin
            state_q <= S_RATE_WAIT;
          end
        end
        S_RATE_WAIT: begin
          if (div_done) begin
            rate_hold_q <= (|div_quot[DIV_NUM_W-1:16]) ? 16'hFFFF : div_quot[15:0];
            state_q     <= S_OUT;
          end
        end
        // hand the result to the output register once it is free
        S_OUT: begin
          if (!out_valid_q || out_ready_i) begin
            out_q.blink_seen        <= blink_seen_q;
            out_q.eyes_shut         <= shut_flag_q;
            out_q.closed_fraction   <= frac_q;
            out_q.blinks_per_minute <= rate_hold_q;
            out_valid_q             <= 1'b1;
            state_q                 <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

`ifndef ASSERT_OFF
  // ring occupancy never exceeds its depth
  a_hist_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    hist_count_q <= HCW'(HISTORY_DEPTH))
    else $error("history count over depth");

  // closed entries are a subset of the history
  a_shut_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    shut_count_q <= hist_count_q)
    else $error("closed count over history count");

  a_blink_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    blink_count_q <= BCW'(BLINK_DEPTH))
    else $error("blink count over depth");

  // an accepted frame keeps the input closed on the next cycle
  a_one_frame: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> !in_ready_o)
    else $error("second frame accepted while busy");

  // divider finishes only while the sequencer waits for it
  a_div_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> (state_q == S_FRAC_WAIT || state_q == S_RATE_WAIT))
    else $error("divider result with nobody waiting");
`endif

endmodule

// ===== tb/sv/bpm_checker.sv =====
`timescale 1ns / 1ps

module bpm_checker (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  input  logic                         in_ready_i,
  input  bpm_pkg::in_t                 in_data_i,
  input  logic                         out_valid_i,
  input  logic                         out_ready_i,
  input  bpm_pkg::out_t                out_data_i,
  input  logic                         cfg_we_i,
  input  logic [bpm_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [bpm_pkg::CfgDataW-1:0] cfg_data_i,
  output int unsigned                  fail_count_o,
  output int unsigned                  pending_o
);

  localparam int unsigned HistDepth  = 256;
  localparam int unsigned BlinkDepth = 64;
  // 60000 ms per minute, scaled by 64 for the Q10.6 rate
  localparam logic [63:0] MinuteQ6   = 64'd3840000;

  // shadow copies of the registers
  logic [15:0] thr_q;
  logic [15:0] debounce_q;
  logic [15:0] shut_win_q;
  logic [19:0] blink_win_q;

  // eye state
  logic        shut_q;
  logic        have_blink_q;
  logic [31:0] last_blink_ms;
  logic [15:0] rate_q;

  // frame history ring
  logic [31:0] hist_ms   [HistDepth];
  logic        hist_shut [HistDepth];
  int unsigned hist_head;
  int unsigned hist_fill;
  int unsigned hist_shut_fill;

  // blink time ring
  logic [31:0] blink_ms [BlinkDepth];
  int unsigned blink_head;
  int unsigned blink_fill;

  bpm_pkg::out_t predicted_reports [$];
  int unsigned   mismatches;

  // retire the oldest frame of the history
  function automatic void drop_oldest_frame();
    if (hist_fill != 0) begin
      if (hist_shut[hist_head]) hist_shut_fill--;
      hist_head = (hist_head + 1) % HistDepth;
      hist_fill--;
    end
  endfunction

  // retire the oldest remembered blink
  function automatic void drop_oldest_blink();
    if (blink_fill != 0) begin
      blink_head = (blink_head + 1) % BlinkDepth;
      blink_fill--;
    end
  endfunction

  // perclos and blink rate after one frame
  function automatic bpm_pkg::out_t score_frame(bpm_pkg::in_t f);
    logic          shut_now;
    logic          counted;
    logic [31:0]   age;
    logic [63:0]   rate;
    bpm_pkg::out_t r;
    shut_now = f.eye_ratio < thr_q;
    counted  = 1'b0;

    // append the frame, then age out stale history
    if (hist_fill >= HistDepth) drop_oldest_frame();
    hist_ms[(hist_head + hist_fill) % HistDepth]   = f.time_ms;
    hist_shut[(hist_head + hist_fill) % HistDepth] = shut_now;
    hist_fill++;
    if (shut_now) hist_shut_fill++;
    while (hist_fill != 0) begin
      age = f.time_ms - hist_ms[hist_head];
      if (age <= 32'(shut_win_q)) break;
      drop_oldest_frame();
    end

    // closed-to-open edge with debounce
    if (shut_now) begin
      shut_q = 1'b1;
    end else if (shut_q) begin
      shut_q = 1'b0;
      age = f.time_ms - last_blink_ms;
      if (!have_blink_q || age > 32'(debounce_q)) begin
        if (blink_fill >= BlinkDepth) drop_oldest_blink();
        blink_ms[(blink_head + blink_fill) % BlinkDepth] = f.time_ms;
        blink_fill++;
        have_blink_q  = 1'b1;
        last_blink_ms = f.time_ms;
        counted       = 1'b1;
      end
    end

    if (hist_fill == 0) begin
      r.closed_fraction = '0;
    end else begin
      r.closed_fraction = 17'(((64'(hist_shut_fill) << 16) + 64'(hist_fill / 2)) /
                              64'(hist_fill));
    end

    // blink rate over the remembered blinks
    while (blink_fill != 0) begin
      age = f.time_ms - blink_ms[blink_head];
      if (age <= 32'(blink_win_q)) break;
      drop_oldest_blink();
    end
    if (blink_fill == 0) begin
      rate_q = '0;
    end else begin
      age = f.time_ms - blink_ms[blink_head];
      if (age != 0) begin
        rate   = (64'(blink_fill) * MinuteQ6 + 64'(age >> 1)) / 64'(age);
        rate_q = (rate > 64'd65535) ? 16'hFFFF : rate[15:0];
      end
    end

    r.blink_seen        = counted;
    r.eyes_shut         = shut_q;
    r.blinks_per_minute = rate_q;
    return r;
  endfunction

  // watch config, results and frames
  always @(posedge clk_i or negedge rst_ni) begin
    bpm_pkg::out_t want;
    if (!rst_ni) begin
      thr_q          = bpm_pkg::ClosedThresholdRst;
      debounce_q     = bpm_pkg::DebounceMsRst;
      shut_win_q     = bpm_pkg::ClosedWindowMsRst;
      blink_win_q    = bpm_pkg::BlinkWindowMsRst;
      shut_q         = 1'b0;
      have_blink_q   = 1'b0;
      last_blink_ms  = '0;
      rate_q         = '0;
      hist_head      = 0;
      hist_fill      = 0;
      hist_shut_fill = 0;
      blink_head     = 0;
      blink_fill     = 0;
      mismatches     = 0;
      predicted_reports.delete();
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          bpm_pkg::RegClosedThreshold: thr_q       = cfg_data_i[15:0];
          bpm_pkg::RegDebounceMs:      debounce_q  = cfg_data_i[15:0];
          bpm_pkg::RegClosedWindowMs:  shut_win_q  = cfg_data_i[15:0];
          bpm_pkg::RegBlinkWindowMs:   blink_win_q = cfg_data_i[19:0];
          default: ;
        endcase
      end

      // compare a result transaction with the oldest prediction
      if (out_valid_i && out_ready_i) begin
        if (predicted_reports.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("unexpected result: blink %0d shut %0d perclos %0d rate %0d",
                     out_data_i.blink_seen, out_data_i.eyes_shut,
                     out_data_i.closed_fraction, out_data_i.blinks_per_minute);
          end
        end else begin
          want = predicted_reports[0];
          predicted_reports.delete(0);
          if (want.blink_seen !== out_data_i.blink_seen ||
              want.eyes_shut !== out_data_i.eyes_shut ||
              want.closed_fraction !== out_data_i.closed_fraction ||
              want.blinks_per_minute !== out_data_i.blinks_per_minute) begin
            mismatches++;
            if (mismatches <= 10) begin
              $display("mismatch at %0t: expected blink %0d shut %0d perclos %0d rate %0d",
                       $realtime, want.blink_seen, want.eyes_shut,
                       want.closed_fraction, want.blinks_per_minute);
              $display("                 got      blink %0d shut %0d perclos %0d rate %0d",
                       out_data_i.blink_seen, out_data_i.eyes_shut,
                       out_data_i.closed_fraction, out_data_i.blinks_per_minute);
            end
          end
        end
      end

      if (in_valid_i && in_ready_i) begin
        predicted_reports.insert(predicted_reports.size(), score_frame(in_data_i));
      end
    end
    fail_count_o = mismatches;
    pending_o    = predicted_reports.size();
  end

endmodule

// ===== tb/sv/tb_blink_perclos_monitor_unit.sv =====
`timescale 1ns / 1ps

module tb_blink_perclos_monitor_unit;

  logic                         clk       = 1'b0;
  logic                         rst_n     = 1'b0;
  logic                         in_valid  = 1'b0;
  logic                         in_ready;
  bpm_pkg::in_t                 in_data   = '0;
  logic                         out_valid;
  logic                         out_ready = 1'b0;
  bpm_pkg::out_t                out_data;
  logic                         cfg_we    = 1'b0;
  logic [bpm_pkg::CfgIdxW-1:0]  cfg_idx   = '0;
  logic [bpm_pkg::CfgDataW-1:0] cfg_data  = '0;

  int unsigned fail_count;
  int unsigned pending;
  int unsigned idle_pct = 0;
  int unsigned rx_hold  = 0;
  logic [31:0] clock_ms = '0;

  blink_perclos_monitor_unit dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_data_o  (out_data),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_data_i  (cfg_data)
  );

  bpm_checker u_checker (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_valid_i   (in_valid),
    .in_ready_i   (in_ready),
    .in_data_i    (in_data),
    .out_valid_i  (out_valid),
    .out_ready_i  (out_ready),
    .out_data_i   (out_data),
    .cfg_we_i     (cfg_we),
    .cfg_idx_i    (cfg_idx),
    .cfg_data_i   (cfg_data),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  // 2 ns clock
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // receiver stalls in random bursts
  always @(negedge clk) begin
    if (rx_hold == 0 && idle_pct != 0 && $urandom_range(0, 99) < idle_pct)
      rx_hold = $urandom_range(1, 18);
    if (rx_hold != 0) begin
      out_ready <= 1'b0;
      rx_hold = rx_hold - 1;
    end else begin
      out_ready <= 1'b1;
    end
  end

  // advance the frame clock by a random step
  function automatic logic [31:0] tick(int unsigned dt_max);
    clock_ms = clock_ms + $urandom_range(0, dt_max);
    return clock_ms;
  endfunction

  function automatic logic [15:0] shut_ratio(logic [15:0] thr);
    return (thr == 0) ? 16'd0 : 16'($urandom_range(0, thr - 1));
  endfunction

  function automatic logic [15:0] open_ratio(logic [15:0] thr);
    return 16'($urandom_range(thr, 16'hFFFF));
  endfunction

  // one frame transaction, entered and left at a falling edge
  task automatic send_frame(input logic [15:0] ratio, input logic [31:0] stamp);
    if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 18)) @(negedge clk);
    end
    in_valid          <= 1'b1;
    in_data.eye_ratio <= ratio;
    in_data.time_ms   <= stamp;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
  endtask

  // drain all results, then let the block go quiet
  task automatic settle();
    while (pending != 0) @(negedge clk);
    repeat (100) @(negedge clk);
  endtask

  task automatic load_settings(input logic [15:0] thr, input logic [15:0] deb,
                               input logic [15:0] shut_win, input logic [19:0] blink_win);
    cfg_we   <= 1'b1;
    cfg_idx  <= bpm_pkg::RegClosedThreshold;
    cfg_data <= 20'(thr);
    @(negedge clk);
    cfg_idx  <= bpm_pkg::RegDebounceMs;
    cfg_data <= 20'(deb);
    @(negedge clk);
    cfg_idx  <= bpm_pkg::RegClosedWindowMs;
    cfg_data <= 20'(shut_win);
    @(negedge clk);
    cfg_idx  <= bpm_pkg::RegBlinkWindowMs;
    cfg_data <= blink_win;
    @(negedge clk);
    cfg_we   <= 1'b0;
  endtask

  // random frames, mostly closed runs followed by open runs
  task automatic run_phase(input logic [15:0] thr, input logic [15:0] deb,
                           input logic [15:0] shut_win, input logic [19:0] blink_win,
                           input int unsigned dt_max, input int unsigned run_max,
                           input int unsigned n_items, input int unsigned idle);
    int unsigned sent;
    int unsigned pick;
    int unsigned n_shut;
    int unsigned n_open;
    settle();
    load_settings(thr, deb, shut_win, blink_win);
    idle_pct = idle;
    clock_ms = $urandom;
    sent     = 0;
    while (sent < n_items) begin
      pick = $urandom_range(0, 99);
      if (pick < 78) begin
        n_shut = $urandom_range(1, run_max);
        n_open = $urandom_range(1, run_max);
        repeat (n_shut) send_frame(shut_ratio(thr), tick(dt_max));
        repeat (n_open) send_frame(open_ratio(thr), tick(dt_max));
        sent += n_shut + n_open;
      end else if (pick < 90) begin
        send_frame(16'($urandom), tick(dt_max));
        sent++;
      end else if (pick < 96) begin
        // right at the threshold or one below
        send_frame((pick[0] && thr != 0) ? thr - 16'd1 : thr, tick(dt_max));
        sent++;
      end else begin
        // time jumps, forward anywhere or a little backwards
        if (pick < 98) clock_ms = clock_ms + $urandom;
        else clock_ms = clock_ms - $urandom_range(1, 2000);
        send_frame(16'($urandom), clock_ms);
        sent++;
      end
    end
    in_valid <= 1'b0;
  endtask

  // stimulus and verdict
  initial begin
    repeat (2) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed frames on reset settings
    idle_pct = 10;
    send_frame(16'hFFFF, 32'd1000);
    send_frame(16'h0000, 32'd1000);
    send_frame(16'h0000, 32'd1010);
    send_frame(16'd3277, 32'd1020);     // open at threshold, first blink, zero span
    send_frame(16'd3276, 32'd1030);
    send_frame(16'd40000, 32'd1100);    // inside debounce
    send_frame(16'h0000, 32'd1150);
    send_frame(16'd20000, 32'd1401);    // second blink, rate from span
    send_frame(16'h0000, 32'd1500);
    send_frame(16'd20000, 32'd1601);    // exactly at debounce, not counted
    send_frame(16'h0000, 32'd7000);     // whole history ages out
    send_frame(16'd30000, 32'd7000);
    send_frame(16'h0000, 32'd500);      // time runs backwards
    send_frame(16'd20000, 32'd501);
    send_frame(16'h0000, 32'hFFFF_FF00);
    send_frame(16'd50000, 32'h0000_0100); // wrap of the time stamp
    send_frame(16'h0000, 32'h0000_0200);
    send_frame(16'd50000, 32'h0000_0400);
    send_frame(16'h0000, 32'h0000_1788); // age equal to window survives
    send_frame(16'hFFFF, 32'h0000_1789);
    send_frame(16'h8000, 32'h0000_1800);
    in_valid <= 1'b0;

    // reset values written back, typical frame rate
    run_phase(16'd3277, 16'd200, 16'd5000, 20'd60000, 40, 8, 180, 15);
    // full rings, no debounce, saturating rate
    run_phase(16'hFFFF, 16'd0, 16'hFFFF, 20'hFFFFF, 3, 2, 300, 5);
    // nothing ever closed, one-millisecond blink window
    run_phase(16'd0, 16'hFFFF, 16'hFFFF, 20'd1, 2, 4, 50, 25);
    // longest debounce
    run_phase(16'($urandom_range(2000, 20000)), 16'hFFFF,
              16'($urandom_range(1, 3000)), 20'($urandom_range(1, 20'hFFFFF)),
              400, 8, 140, 10);
    // zero windows, only same-stamp entries survive
    run_phase(16'd20000, 16'd0, 16'd0, 20'd0, 1, 3, 90, 20);
    // anything goes
    run_phase(16'($urandom), 16'($urandom), 16'($urandom), 20'($urandom),
              $urandom_range(1, 3000), 6, 140, 8);
    // last stretch without idling
    run_phase(16'd16384, 16'd100, 16'd2000, 20'd10000, 50, 6, 180, 0);

    settle();
    if (fail_count == 0 && pending == 0)
      $display("RESULT: OK");
    else
      $display("RESULT: ERROR");
    $finish;
  end

  // run time limit
  initial begin
    #2000000;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule
